### hw/rtl/iso_week_from_date_top_defines.svh
// Assertion helpers, clocked on clk, quiet while rst_n is low.
`ifndef ISO_WEEK_FROM_DATE_TOP_DEFINES_SVH
`define ISO_WEEK_FROM_DATE_TOP_DEFINES_SVH

`define IWFD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iwfd assertion failed");

`define IWFD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iwfd assertion failed");

`endif

### hw/rtl/iwfd_pkg.sv
package iwfd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WEEK_W  = 6;
    localparam int DOY_W   = 9;
    localparam int Y1_W    = YEAR_W + 1;

    // floor(x / 100) = (x * RECIP_100) >> SHIFT_100, exact for x < 16800
    localparam int RECIP_100 = 5243;
    localparam int SHIFT_100 = 19;
    localparam int R100_W    = 13;

    // floor(x / 7) = (x * RECIP_7) >> SHIFT_7, exact for x < 512
    localparam int RECIP_7 = 2341;
    localparam int SHIFT_7 = 14;
    localparam int R7_W    = 12;

    localparam int YEAR_OFFSET = 399;

    localparam logic [DOY_W-1:0]  DAYS_LEAP  = 9'd366;
    localparam logic [DOY_W-1:0]  DAYS_NORM  = 9'd365;
    localparam logic [WEEK_W-1:0] WEEK_LONG  = 6'd53;
    localparam logic [WEEK_W-1:0] WEEK_SHORT = 6'd52;
    localparam logic [WEEK_W-1:0] WEEK_FIRST = 6'd1;
    localparam logic [WEEK_W-1:0] WEEK_NONE  = 6'd0;

    localparam logic [2:0] WD_THURSDAY = 3'd4;
    localparam logic [2:0] WD_FRIDAY   = 3'd5;
    localparam logic [2:0] WD_SATURDAY = 3'd6;

    typedef struct packed {
        logic       leap;
        logic       prev_leap;
        logic [2:0] jan1;       // 1 = Monday .. 7 = Sunday
    } year_info_t;

endpackage

### hw/rtl/iwfd_year_info.sv
module iwfd_year_info
    import iwfd_pkg::*;
(
    input  logic              clk,
    input  logic [YEAR_W-1:0] year,
    output year_info_t        info
);

    localparam int PROD_W = Y1_W + R100_W;
    localparam int Q_W    = PROD_W - SHIFT_100;

    logic [Y1_W-1:0]   y1;
    logic [PROD_W-1:0] prod_y;
    logic [PROD_W-1:0] prod_y1;

    logic [YEAR_W-1:0] year_reg;
    logic [Q_W-1:0]    qy_reg;
    logic [Q_W-1:0]    qy1_reg;
    year_info_t        info_reg;
    year_info_t        info_next;

    logic [Y1_W-1:0] y1_b;
    logic [Y1_W-1:0] ry_full;
    logic [Y1_W-1:0] ry1_full;
    logic [6:0]      ry;
    logic [6:0]      ry1;
    logic [7:0]      jan1_sum;

    function automatic logic [2:0] mod7(input logic [7:0] v);
        logic [4:0] f1;
        logic [3:0] f2;
        begin
            f1 = {3'b0, v[7:6]} + {2'b0, v[5:3]} + {2'b0, v[2:0]};
            f2 = {2'b0, f1[4:3]} + {1'b0, f1[2:0]};
            if (f2 >= 4'd7)
            begin
                f2 = f2 - 4'd7;
            end
            mod7 = f2[2:0];
        end
    endfunction

    function automatic logic [Y1_W-1:0] times100(input logic [Q_W-1:0] q);
        logic [Y1_W-1:0] qx;
        begin
            qx = Y1_W'(q);
            times100 = (qx << 6) + (qx << 5) + (qx << 2);
        end
    endfunction

    assign y1      = Y1_W'(year) + Y1_W'(YEAR_OFFSET);
    assign prod_y  = PROD_W'(year) * PROD_W'(RECIP_100);
    assign prod_y1 = PROD_W'(y1) * PROD_W'(RECIP_100);

    always_ff @(posedge clk)
    begin
        year_reg <= year;
        qy_reg   <= prod_y[PROD_W-1:SHIFT_100];
        qy1_reg  <= prod_y1[PROD_W-1:SHIFT_100];
    end

    always_comb
    begin
        y1_b     = Y1_W'(year_reg) + Y1_W'(YEAR_OFFSET);
        ry_full  = Y1_W'(year_reg) - times100(qy_reg);
        ry1_full = y1_b - times100(qy1_reg);
        ry       = ry_full[6:0];
        ry1      = ry1_full[6:0];
        // 5 * (century mod 4) + year-in-century + year-in-century / 4, all on year - 1
        jan1_sum = {4'b0, qy1_reg[1:0], 2'b0} + {6'b0, qy1_reg[1:0]}
                 + {1'b0, ry1} + {3'b0, ry1[6:2]};
        info_next.leap      = (year_reg[1:0] == 2'b00)
                            && ((ry != 7'd0) || (qy_reg[1:0] == 2'b00));
        info_next.prev_leap = (year_reg != '0) && (y1_b[1:0] == 2'b00)
                            && ((ry1 != 7'd0) || (qy1_reg[1:0] == 2'b00));
        info_next.jan1      = mod7(jan1_sum) + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        info_reg <= info_next;
    end

    assign info = info_reg;

endmodule

### hw/rtl/iso_week_from_date_top.sv
// ISO 8601 week number and week-year of a Gregorian date.
// One request per cycle; busy is always low.
// done pulses for one cycle per request, after the input, stage 1, stage 2 and done valid registers.
// Four register stages: input, year division, year info / day of year, result.
// Reset clears only the valid flags of the stages; data registers are not reset.
`include "iso_week_from_date_top_defines.svh"

module iso_week_from_date_top
    import iwfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [YEAR_W-1:0]  year,
    input  logic [MONTH_W-1:0] month,
    input  logic [DAY_W-1:0]   day,
    output logic               done,
    output logic [WEEK_W-1:0]  week_number,
    output logic [YEAR_W-1:0]  week_year,
    output logic               bad_month
);

    localparam int T_PROD_W = DOY_W + R7_W;
    localparam int Q7_W     = T_PROD_W - SHIFT_7;

    logic                in_valid_reg;
    logic [YEAR_W-1:0]   in_year_reg;
    logic [MONTH_W-1:0]  in_month_reg;
    logic [DAY_W-1:0]    in_day_reg;

    logic                s1_valid_reg;
    logic [YEAR_W-1:0]   s1_year_reg;
    logic                s1_bad_reg;
    logic                s1_late_reg;
    logic [DOY_W-1:0]    s1_doy_reg;
    logic [DOY_W-1:0]    s1_doy_next;
    logic                s1_bad_next;

    logic                s2_valid_reg;
    logic [YEAR_W-1:0]   s2_year_reg;
    logic                s2_bad_reg;
    logic                s2_late_reg;
    logic [DOY_W-1:0]    s2_doy_reg;

    year_info_t          info;

    logic [DOY_W-1:0]    doy;
    logic [DOY_W-1:0]    t;
    logic [T_PROD_W-1:0] t_prod;
    logic [Q7_W-1:0]     q7;
    logic [DOY_W-1:0]    t_rem;
    logic [2:0]          wday;
    logic [DOY_W-1:0]    ylen;
    logic                in_prev_year;
    logic                in_next_year;

    logic                done_reg;
    logic [WEEK_W-1:0]   week_reg;
    logic [WEEK_W-1:0]   week_next;
    logic [YEAR_W-1:0]   wyear_reg;
    logic [YEAR_W-1:0]   wyear_next;
    logic                bad_reg;

    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        begin
            case (m)
                4'd2:    days_before = 9'd31;
                4'd3:    days_before = 9'd59;
                4'd4:    days_before = 9'd90;
                4'd5:    days_before = 9'd120;
                4'd6:    days_before = 9'd151;
                4'd7:    days_before = 9'd181;
                4'd8:    days_before = 9'd212;
                4'd9:    days_before = 9'd243;
                4'd10:   days_before = 9'd273;
                4'd11:   days_before = 9'd304;
                4'd12:   days_before = 9'd334;
                default: days_before = 9'd0;
            endcase
        end
    endfunction

    assign busy = 1'b0;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_year_reg  <= year;
        in_month_reg <= month;
        in_day_reg   <= day;
    end

    // stage 1: month table
    always_comb
    begin
        s1_bad_next = !(in_month_reg inside {[4'd1:4'd12]});
        s1_doy_next = DOY_W'(in_day_reg) + days_before(in_month_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_year_reg <= in_year_reg;
        s1_bad_reg  <= s1_bad_next;
        s1_late_reg <= (in_month_reg > 4'd2);
        s1_doy_reg  <= s1_doy_next;
        s2_year_reg <= s1_year_reg;
        s2_bad_reg  <= s1_bad_reg;
        s2_late_reg <= s1_late_reg;
        s2_doy_reg  <= s1_doy_reg;
    end

    iwfd_year_info u_year_info
    (
        .clk  (clk),
        .year (in_year_reg),
        .info (info)
    );

    // stage 3: weekday and week
    always_comb
    begin
        doy    = s2_doy_reg + DOY_W'(info.leap && s2_late_reg);
        t      = doy + DOY_W'(info.jan1) + DOY_W'(5);
        t_prod = T_PROD_W'(t) * T_PROD_W'(RECIP_7);
        q7     = t_prod[T_PROD_W-1:SHIFT_7];
        t_rem  = t - ((DOY_W'(q7) << 3) - DOY_W'(q7));
        wday   = t_rem[2:0] + 3'd1;
        ylen   = info.leap ? DAYS_LEAP : DAYS_NORM;

        in_prev_year = ((doy + DOY_W'(info.jan1)) <= DOY_W'(8))
                    && (info.jan1 > WD_THURSDAY);
        in_next_year = ({1'b0, ylen} + 10'(wday)) < ({1'b0, doy} + 10'd4);

        week_next  = WEEK_NONE;
        wyear_next = s2_year_reg;
        if (s2_bad_reg)
        begin
            week_next  = WEEK_NONE;
            wyear_next = s2_year_reg;
        end
        else if (in_prev_year)
        begin
            wyear_next = s2_year_reg - YEAR_W'(1);
            if ((info.jan1 == WD_FRIDAY) || ((info.jan1 == WD_SATURDAY) && info.prev_leap))
            begin
                week_next = WEEK_LONG;
            end
            else
            begin
                week_next = WEEK_SHORT;
            end
        end
        else if (in_next_year)
        begin
            wyear_next = s2_year_reg + YEAR_W'(1);
            week_next  = WEEK_FIRST;
        end
        else
        begin
            week_next = WEEK_W'(q7) - WEEK_W'(info.jan1 > WD_THURSDAY);
        end
    end

    always_ff @(posedge clk)
    begin
        week_reg  <= week_next;
        wyear_reg <= wyear_next;
        bad_reg   <= s2_bad_reg;
    end

    assign done        = done_reg;
    assign week_number = week_reg;
    assign week_year   = wyear_reg;
    assign bad_month   = bad_reg;

    `IWFD_ASSERT_IMP(a_req_to_done, start && !busy, ##4 done)
    `IWFD_ASSERT_IMP(a_done_has_req, done, $past(start, 4))
    `IWFD_ASSERT_NXT(a_stage_to_done, s2_valid_reg, done)
    `IWFD_ASSERT_IMP(a_bad_zero_week, done && bad_month, week_number == WEEK_NONE)
    `IWFD_ASSERT_IMP(a_week_range, done && !bad_month, week_number <= WEEK_LONG)

endmodule
